/* design/kv_cache_dequant_hadamard_unit_macros.svh */
// Assertion macros for the KV cache dequantizer.
// Used only by the top level; no other dependencies.
`ifndef KV_CACHE_DEQUANT_HADAMARD_UNIT_MACROS_SVH
`define KV_CACHE_DEQUANT_HADAMARD_UNIT_MACROS_SVH

// Same-cycle implication under reset.
`define KVDH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kvdh check failed");

// Next-cycle implication under reset.
`define KVDH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kvdh check failed");

`endif

/* design/kvdh_pkg.sv */
// Shared types, constants and arithmetic helpers for the KV cache dequantizer.
// No dependencies.
package kvdh_pkg;

    localparam int MaxHead     = 256;
    localparam int AddrW       = 8;
    localparam int GroupLog2   = 5;
    localparam int NumGroups   = 8;
    localparam int DataW       = 24;
    localparam int WorkW       = 40;

    typedef enum logic [2:0] {
        CMD_CENTROID = 3'd0,
        CMD_SIGN     = 3'd1,
        CMD_GROUP    = 3'd2,
        CMD_KEY_BYTE = 3'd3,
        CMD_VAL_BYTE = 3'd4,
        CMD_COMPUTE  = 3'd5,
        CMD_READ     = 3'd6,
        CMD_NOP      = 3'd7
    } t_cmd;

    localparam logic [1:0] REG_HEAD_LOG2   = 2'd0;
    localparam logic [1:0] REG_KEY_BITS    = 2'd1;
    localparam logic [1:0] REG_VAL_BITS    = 2'd2;
    localparam logic [1:0] REG_KEY_SIGNED  = 2'd3;

    typedef enum logic [3:0] {
        DP_IDLE, DP_VB0, DP_VB1, DP_CEN, DP_MUL, DP_WINIT,
        DP_BRX, DP_BRY, DP_BWX, DP_BWY,
        DP_RA, DP_RB, DP_RC, DP_RD, DP_RE
    } t_dp_op;

    typedef struct packed {
        logic   ld;
        t_dp_op op;
        logic [AddrW-1:0] elem;
        logic [AddrW-1:0] bx;
        logic [AddrW-1:0] by;
    } t_ctrl;

    typedef struct packed {
        logic [3:0] lg;
        logic       out_free;
    } t_stat;

    // Round to nearest, ties to even, arithmetic right shift by sh.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input logic [4:0] sh);
        logic signed [63:0] q;
        logic [63:0] msk;
        logic [63:0] rem;
        logic [63:0] half;
        q    = v >>> sh;
        msk  = (64'd1 << sh) - 64'd1;
        rem  = v & msk;
        half = 64'd1 << (sh - 5'd1);
        if (rem > half || (rem == half && q[0])) begin
            q = q + 64'sd1;
        end
        return q;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q0.24 normalization, 1/sqrt(head size).
    function automatic logic [21:0] norm_q24(input logic [3:0] lg);
        logic [21:0] r;
        case (lg)
            4'd6:    r = 22'd2097152;
            4'd7:    r = 22'd1482910;
            default: r = 22'd1048576;
        endcase
        return r;
    endfunction

    // Element index mask for the head size.
    function automatic logic [AddrW-1:0] head_mask(input logic [3:0] lg);
        return 8'hFF >> (4'd8 - lg);
    endfunction

endpackage

/* design/kvdh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kvdh_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* design/kvdh_ctrl.sv */
// Sequencer for the KV cache dequantizer: walks the fill, butterfly and read steps.
// Depends on kvdh_pkg; drives kvdh_datapath through t_ctrl.
module kvdh_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [2:0]         i_cmd,
    input  logic [7:0]         i_index,
    input  kvdh_pkg::t_stat    i_stat,
    output logic               o_in_stall,
    output kvdh_pkg::t_ctrl    o_ctrl
);
    typedef enum logic [4:0] {
        S_IDLE, S_CI_A, S_CI_B, S_CI_C, S_CI_D, S_CI_E,
        S_BF_RX, S_BF_RY, S_BF_WX, S_BF_WY,
        S_RD_A, S_RD_B, S_RD_C, S_RD_D, S_RD_E
    } t_state;

    t_state     r_state;
    logic [7:0] r_i;
    logic [2:0] r_s;
    logic [6:0] r_j;
    logic       accept;
    logic [7:0] mask;
    logic [7:0] jj;
    logic [7:0] lowm;
    logic [7:0] bx;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign mask       = kvdh_pkg::head_mask(i_stat.lg);

    // Butterfly pair addresses: insert a zero at bit s of the pair count.
    assign jj   = {1'b0, r_j};
    assign lowm = (8'd1 << r_s) - 8'd1;
    assign bx   = ((jj >> r_s) << (r_s + 3'd1)) | (jj & lowm);

    always_comb begin
        o_ctrl.ld   = accept;
        o_ctrl.elem = r_i;
        o_ctrl.bx   = bx;
        o_ctrl.by   = bx | (8'd1 << r_s);
        case (r_state)
            S_CI_A:  o_ctrl.op = kvdh_pkg::DP_VB0;
            S_CI_B:  o_ctrl.op = kvdh_pkg::DP_VB1;
            S_CI_C:  o_ctrl.op = kvdh_pkg::DP_CEN;
            S_CI_D:  o_ctrl.op = kvdh_pkg::DP_MUL;
            S_CI_E:  o_ctrl.op = kvdh_pkg::DP_WINIT;
            S_BF_RX: o_ctrl.op = kvdh_pkg::DP_BRX;
            S_BF_RY: o_ctrl.op = kvdh_pkg::DP_BRY;
            S_BF_WX: o_ctrl.op = kvdh_pkg::DP_BWX;
            S_BF_WY: o_ctrl.op = kvdh_pkg::DP_BWY;
            S_RD_A:  o_ctrl.op = kvdh_pkg::DP_RA;
            S_RD_B:  o_ctrl.op = kvdh_pkg::DP_RB;
            S_RD_C:  o_ctrl.op = kvdh_pkg::DP_RC;
            S_RD_D:  o_ctrl.op = kvdh_pkg::DP_RD;
            S_RD_E:  o_ctrl.op = i_stat.out_free ? kvdh_pkg::DP_RE : kvdh_pkg::DP_IDLE;
            default: o_ctrl.op = kvdh_pkg::DP_IDLE;
        endcase
    end

    // Advance state and loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_s     <= '0;
            r_j     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && i_cmd == kvdh_pkg::CMD_COMPUTE) begin
                        r_i     <= '0;
                        r_state <= S_CI_A;
                    end else if (accept && i_cmd == kvdh_pkg::CMD_READ) begin
                        r_i     <= i_index & mask;
                        r_state <= S_RD_A;
                    end
                end
                S_CI_A: r_state <= S_CI_B;
                S_CI_B: r_state <= S_CI_C;
                S_CI_C: r_state <= S_CI_D;
                S_CI_D: r_state <= S_CI_E;
                S_CI_E: begin
                    if (r_i == mask) begin
                        r_s     <= '0;
                        r_j     <= '0;
                        r_state <= S_BF_RX;
                    end else begin
                        r_i     <= r_i + 8'd1;
                        r_state <= S_CI_A;
                    end
                end
                S_BF_RX: r_state <= S_BF_RY;
                S_BF_RY: r_state <= S_BF_WX;
                S_BF_WX: r_state <= S_BF_WY;
                S_BF_WY: begin
                    if (r_j == mask[7:1]) begin
                        if (r_s == i_stat.lg[2:0] - 3'd1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_s     <= r_s + 3'd1;
                            r_j     <= '0;
                            r_state <= S_BF_RX;
                        end
                    end else begin
                        r_j     <= r_j + 7'd1;
                        r_state <= S_BF_RX;
                    end
                end
                S_RD_A: r_state <= S_RD_B;
                S_RD_B: r_state <= S_RD_C;
                S_RD_C: r_state <= S_RD_D;
                S_RD_D: r_state <= S_RD_E;
                S_RD_E: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* design/kvdh_datapath.sv */
// Datapath: stores, configuration, unpacking, multipliers, butterfly and output register.
// Depends on kvdh_pkg and kvdh_ram; steered by kvdh_ctrl through t_ctrl.
module kvdh_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kvdh_pkg::t_ctrl     i_ctrl,
    output kvdh_pkg::t_stat     o_stat,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [3:0]          i_cfg_data,
    input  logic [2:0]          i_cmd,
    input  logic [7:0]          i_index,
    input  logic signed [23:0]  i_data_a,
    input  logic signed [23:0]  i_data_b,
    input  logic signed [23:0]  i_data_c,
    input  logic [7:0]          i_packed_byte,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [7:0]          o_element_index,
    output logic signed [31:0]  o_key_result,
    output logic signed [31:0]  o_value_result
);
    // Configuration registers
    logic [3:0] r_head_lg, r_kcode_width, r_val_bits;
    logic       r_kcode_twos;
    logic [3:0] lg, kbits, vbits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_lg     <= 4'd7;
            r_kcode_width <= 4'd4;
            r_val_bits    <= 4'd4;
            r_kcode_twos  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kvdh_pkg::REG_HEAD_LOG2:  r_head_lg     <= i_cfg_data;
                kvdh_pkg::REG_KEY_BITS:   r_kcode_width <= i_cfg_data;
                kvdh_pkg::REG_VAL_BITS:   r_val_bits    <= i_cfg_data;
                kvdh_pkg::REG_KEY_SIGNED: r_kcode_twos  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign lg    = (r_head_lg < 4'd6) ? 4'd6 : ((r_head_lg > 4'd8) ? 4'd8 : r_head_lg);
    assign kbits = (r_kcode_width < 4'd2) ? 4'd2 :
                   ((r_kcode_width > 4'd8) ? 4'd8 : r_kcode_width);
    assign vbits = (r_val_bits < 4'd2) ? 4'd2 : ((r_val_bits > 4'd8) ? 4'd8 : r_val_bits);

    // Group parameter registers
    logic signed [23:0] r_gks [kvdh_pkg::NumGroups];
    logic signed [23:0] r_gkz [kvdh_pkg::NumGroups];
    logic signed [23:0] r_gvs [kvdh_pkg::NumGroups];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld && i_cmd == kvdh_pkg::CMD_GROUP && i_index < 8'd8) begin
            r_gks[i_index[2:0]] <= i_data_a;
            r_gkz[i_index[2:0]] <= i_data_b;
            r_gvs[i_index[2:0]] <= i_data_c;
        end
    end

    // Unpack positions for the current element
    logic [11:0] vpos, kpos;
    logic [7:0]  vat, kat;
    assign vpos = 12'(i_ctrl.elem) * 12'(vbits);
    assign kpos = 12'(i_ctrl.elem) * 12'(kbits);
    assign vat  = vpos[10:3];
    assign kat  = kpos[10:3];

    // Memories
    logic [23:0] cen_rdata, sgn_rdata;
    logic [7:0]  kb_rdata, vb_rdata;
    logic [39:0] wk_rdata;
    logic        cen_re, kb_re, vb_re, wk_re, wk_we, rd_a;
    logic [7:0]  cen_raddr, kb_raddr, vb_raddr, wk_raddr, wk_waddr;
    logic [39:0] wk_wdata;

    assign rd_a = (i_ctrl.op == kvdh_pkg::DP_RA);

    kvdh_ram #(.Width(24), .Depth(kvdh_pkg::MaxHead)) u_cen (
        .i_clk(i_clk), .i_we(i_ctrl.ld && i_cmd == kvdh_pkg::CMD_CENTROID),
        .i_waddr(i_index), .i_wdata(i_data_a),
        .i_re(cen_re), .i_raddr(cen_raddr), .o_rdata(cen_rdata));

    kvdh_ram #(.Width(24), .Depth(kvdh_pkg::MaxHead)) u_sgn (
        .i_clk(i_clk), .i_we(i_ctrl.ld && i_cmd == kvdh_pkg::CMD_SIGN),
        .i_waddr(i_index), .i_wdata(i_data_a),
        .i_re(rd_a), .i_raddr(i_ctrl.elem), .o_rdata(sgn_rdata));

    kvdh_ram #(.Width(8), .Depth(kvdh_pkg::MaxHead)) u_kb (
        .i_clk(i_clk), .i_we(i_ctrl.ld && i_cmd == kvdh_pkg::CMD_KEY_BYTE),
        .i_waddr(i_index), .i_wdata(i_packed_byte),
        .i_re(kb_re), .i_raddr(kb_raddr), .o_rdata(kb_rdata));

    kvdh_ram #(.Width(8), .Depth(kvdh_pkg::MaxHead)) u_vb (
        .i_clk(i_clk), .i_we(i_ctrl.ld && i_cmd == kvdh_pkg::CMD_VAL_BYTE),
        .i_waddr(i_index), .i_wdata(i_packed_byte),
        .i_re(vb_re), .i_raddr(vb_raddr), .o_rdata(vb_rdata));

    kvdh_ram #(.Width(kvdh_pkg::WorkW), .Depth(kvdh_pkg::MaxHead)) u_work (
        .i_clk(i_clk), .i_we(wk_we), .i_waddr(wk_waddr), .i_wdata(wk_wdata),
        .i_re(wk_re), .i_raddr(wk_raddr), .o_rdata(wk_rdata));

    // Arithmetic registers
    logic [7:0]         r_b0;
    logic signed [47:0] r_prod;
    logic signed [39:0] r_x, r_y;
    logic signed [61:0] r_vp;
    logic signed [36:0] r_t;
    logic signed [26:0] r_kop;
    logic signed [50:0] r_kp;
    logic signed [60:0] r_vp2;
    logic               r_out_valid;
    logic [7:0]         r_out_idx;
    logic [31:0]        r_out_key, r_out_val;

    // Code extraction from two consecutive bytes
    logic [15:0]        vraw, kraw;
    logic [7:0]         vcode, kcode, vmask, kmask;
    logic               kneg;
    logic signed [9:0]  kc;
    logic signed [63:0] init_rnd, t_rnd, key_rnd, val_rnd;
    logic signed [39:0] sum_xy, dif_xy;

    assign vraw  = {vb_rdata, r_b0} >> vpos[2:0];
    assign kraw  = {kb_rdata, r_b0} >> kpos[2:0];
    assign vmask = 8'((9'd1 << vbits) - 9'd1);
    assign kmask = 8'((9'd1 << kbits) - 9'd1);
    assign vcode = vraw[7:0] & vmask;
    assign kcode = kraw[7:0] & kmask;
    assign kneg  = r_kcode_twos && kcode[3'(kbits - 4'd1)];
    assign kc    = signed'({2'b00, kcode}) - (kneg ? signed'(10'd1 << kbits) : 10'sd0);

    assign init_rnd = kvdh_pkg::round_shift(64'(r_prod), 5'd16);
    assign t_rnd    = kvdh_pkg::round_shift(64'(r_vp), 5'd24);
    assign key_rnd  = kvdh_pkg::round_shift(64'(r_kp), 5'd16);
    assign val_rnd  = kvdh_pkg::round_shift(64'(r_vp2), 5'd16);
    assign sum_xy   = r_x + wk_rdata;
    assign dif_xy   = r_x - r_y;

    // Steer memory ports by step
    always_comb begin
        vb_re     = 1'b0;
        vb_raddr  = vat;
        kb_re     = 1'b0;
        kb_raddr  = kat;
        cen_re    = 1'b0;
        cen_raddr = vcode;
        wk_re     = 1'b0;
        wk_raddr  = i_ctrl.elem;
        wk_we     = 1'b0;
        wk_waddr  = i_ctrl.elem;
        wk_wdata  = init_rnd[39:0];
        case (i_ctrl.op)
            kvdh_pkg::DP_VB0: vb_re = 1'b1;
            kvdh_pkg::DP_VB1: begin
                vb_re    = 1'b1;
                vb_raddr = vat + 8'd1;
            end
            kvdh_pkg::DP_CEN:   cen_re = 1'b1;
            kvdh_pkg::DP_WINIT: wk_we  = 1'b1;
            kvdh_pkg::DP_BRX: begin
                wk_re    = 1'b1;
                wk_raddr = i_ctrl.bx;
            end
            kvdh_pkg::DP_BRY: begin
                wk_re    = 1'b1;
                wk_raddr = i_ctrl.by;
            end
            kvdh_pkg::DP_BWX: begin
                wk_we    = 1'b1;
                wk_waddr = i_ctrl.bx;
                wk_wdata = sum_xy;
            end
            kvdh_pkg::DP_BWY: begin
                wk_we    = 1'b1;
                wk_waddr = i_ctrl.by;
                wk_wdata = dif_xy;
            end
            kvdh_pkg::DP_RA: begin
                kb_re = 1'b1;
                wk_re = 1'b1;
            end
            kvdh_pkg::DP_RB: begin
                kb_re    = 1'b1;
                kb_raddr = kat + 8'd1;
            end
            default: ;
        endcase
    end

    // Capture and multiply per step
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            kvdh_pkg::DP_VB1: r_b0   <= vb_rdata;
            kvdh_pkg::DP_MUL: r_prod <= signed'(cen_rdata) * r_gvs[i_ctrl.elem[7:5]];
            kvdh_pkg::DP_BRY: r_x    <= wk_rdata;
            kvdh_pkg::DP_BWX: r_y    <= wk_rdata;
            kvdh_pkg::DP_RB: begin
                r_b0 <= kb_rdata;
                r_vp <= 62'(signed'(wk_rdata)) * 62'(signed'({1'b0, kvdh_pkg::norm_q24(lg)}));
            end
            kvdh_pkg::DP_RC: begin
                r_kop <= (27'(kc) <<< 16) + 27'(r_gkz[i_ctrl.elem[7:5]]);
                r_t   <= t_rnd[36:0];
            end
            kvdh_pkg::DP_RD: begin
                r_kp  <= 51'(r_kop) * 51'(r_gks[i_ctrl.elem[7:5]]);
                r_vp2 <= 61'(r_t) * 61'(signed'(sgn_rdata));
            end
            default: ;
        endcase
    end

    // Output register; load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.op == kvdh_pkg::DP_RE) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == kvdh_pkg::DP_RE) begin
            r_out_idx <= i_ctrl.elem;
            r_out_key <= kvdh_pkg::sat32(key_rnd);
            r_out_val <= kvdh_pkg::sat32(val_rnd);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_element_index = r_out_idx;
    assign o_key_result    = r_out_key;
    assign o_value_result  = r_out_val;
    assign o_stat.lg       = lg;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
endmodule

/* design/kv_cache_dequant_hadamard_unit.sv */
// Top level of the KV cache dequantizer: sequencer plus datapath.
// Depends on kvdh_pkg, kvdh_ctrl, kvdh_datapath and the assertion macro header.
//
// Load commands (centroid, sign, group parameters, key byte, value byte) and
// ignored commands are accepted without stalling the input. A read passes through
// the read steps to the output register, plus any wait while the previous result
// is still held there. A compute fills the work memory element by element on the
// single value-byte and centroid ports, then runs the butterflies in place on the
// one-read, one-write work memory. Input stall stays high for the whole of a compute
// or read.
`include "kv_cache_dequant_hadamard_unit_macros.svh"
module kv_cache_dequant_hadamard_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_cmd,
    input  logic [7:0]         i_index,
    input  logic signed [23:0] i_data_a,
    input  logic signed [23:0] i_data_b,
    input  logic signed [23:0] i_data_c,
    input  logic [7:0]         i_packed_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_element_index,
    output logic signed [31:0] o_key_result,
    output logic signed [31:0] o_value_result
);
    kvdh_pkg::t_ctrl ctrl;
    kvdh_pkg::t_stat stat;

    kvdh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_cmd(i_cmd), .i_index(i_index), .i_stat(stat),
        .o_in_stall(o_in_stall), .o_ctrl(ctrl));

    kvdh_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .o_stat(stat),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_cmd(i_cmd), .i_index(i_index), .i_data_a(i_data_a),
        .i_data_b(i_data_b), .i_data_c(i_data_c), .i_packed_byte(i_packed_byte),
        .i_out_stall(i_out_stall), .o_out_valid(o_out_valid),
        .o_element_index(o_element_index), .o_key_result(o_key_result),
        .o_value_result(o_value_result));

    // A datapath step in flight keeps the input stalled.
    `KVDH_ASSERT_NOW(a_busy_stalls, i_clk, i_rst_n, ctrl.op != kvdh_pkg::DP_IDLE, o_in_stall)
    // A result is never loaded over one still waiting.
    `KVDH_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, ctrl.op == kvdh_pkg::DP_RE, !(o_out_valid && i_out_stall))
    // A load step raises output valid.
    `KVDH_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, ctrl.op == kvdh_pkg::DP_RE, o_out_valid)
endmodule

/* sim/kv_cache_dequant_hadamard_unit_tb.sv */
// Self-checking testbench for kv_cache_dequant_hadamard_unit: a bit-exact
// predictor of the dequantizer checks every result under random handshakes.
// Depends on kvdh_pkg and the kv_cache_dequant_hadamard_unit RTL.

typedef struct {
    logic [7:0]         elem;
    logic signed [31:0] key;
    logic signed [31:0] value;
} t_elem_result;

class dequant_predictor;
    longint      centroid[256];
    longint      sign_vec[256];
    longint      key_scale[8];
    longint      key_zero[8];
    longint      val_scale[8];
    bit [7:0]    kcode_store[256];
    bit [7:0]    val_bytes[256];
    longint      work[256];
    int unsigned head_log2 = 7;
    int unsigned kcode_width = 4;
    int unsigned val_bits = 4;
    bit          kcode_twos = 0;
    t_elem_result expected_elems[$];
    int          errors = 0;

    function void write_reg(logic [1:0] idx, logic [3:0] data);
        case (idx)
            kvdh_pkg::REG_HEAD_LOG2:  head_log2 = data;
            kvdh_pkg::REG_KEY_BITS:   kcode_width = data;
            kvdh_pkg::REG_VAL_BITS:   val_bits = data;
            kvdh_pkg::REG_KEY_SIGNED: kcode_twos = data[0];
            default: ;
        endcase
    endfunction

    // Round to nearest, ties to even, on the magnitude.
    function longint rne_shift(longint v, int sh);
        longint mag;
        longint q;
        longint rem;
        longint half;
        mag = (v < 0) ? -v : v;
        q = mag >>> sh;
        rem = mag & ((64'sd1 <<< sh) - 1);
        half = 64'sd1 <<< (sh - 1);
        if (rem > half || (rem == half && q[0])) q++;
        return (v < 0) ? -q : q;
    endfunction

    function logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // LSB-first code stream, wrapping at the end of the byte store.
    function int unsigned unpack(bit from_keys, int unsigned el, int unsigned bits);
        int unsigned pos;
        int unsigned at;
        int unsigned off;
        int unsigned raw;
        pos = el * bits;
        at = (pos >> 3) % 256;
        off = pos & 7;
        raw = from_keys ? kcode_store[at] : val_bytes[at];
        if (off + bits > 8)
            raw |= (from_keys ? kcode_store[(at + 1) % 256] : val_bytes[(at + 1) % 256]) << 8;
        return (raw >> off) & ((1 << bits) - 1);
    endfunction

    function void note_command(kvdh_pkg::t_cmd cmd, logic [7:0] idx,
                               logic signed [23:0] a, logic signed [23:0] b,
                               logic signed [23:0] c, logic [7:0] pbyte);
        int unsigned lg;
        int unsigned n;
        int unsigned kb;
        int unsigned vb;
        int unsigned e;
        int unsigned g;
        int unsigned w;
        longint kc;
        longint x;
        longint y;
        longint t;
        t_elem_result r;
        lg = (head_log2 < 6) ? 6 : (head_log2 > 8 ? 8 : head_log2);
        n = 1 << lg;
        kb = (kcode_width < 2) ? 2 : (kcode_width > 8 ? 8 : kcode_width);
        vb = (val_bits < 2) ? 2 : (val_bits > 8 ? 8 : val_bits);
        case (cmd)
            kvdh_pkg::CMD_CENTROID: centroid[idx] = a;
            kvdh_pkg::CMD_SIGN:     sign_vec[idx] = a;
            kvdh_pkg::CMD_GROUP: begin
                // Drop out-of-range groups.
                if (idx < 8) begin
                    key_scale[idx] = a;
                    key_zero[idx] = b;
                    val_scale[idx] = c;
                end
            end
            kvdh_pkg::CMD_KEY_BYTE: kcode_store[idx] = pbyte;
            kvdh_pkg::CMD_VAL_BYTE: val_bytes[idx] = pbyte;
            kvdh_pkg::CMD_COMPUTE: begin
                for (int i = 0; i < n; i++)
                    work[i] = rne_shift(centroid[unpack(0, i, vb)] * val_scale[(i / 32) % 8], 16);
                // In-place Walsh-Hadamard butterflies.
                for (w = 1; w < n; w *= 2)
                    for (int base = 0; base < n; base += 2 * w)
                        for (int i = 0; i < w; i++) begin
                            x = work[base + i];
                            y = work[base + w + i];
                            work[base + i] = x + y;
                            work[base + w + i] = x - y;
                        end
            end
            kvdh_pkg::CMD_READ: begin
                e = idx & (n - 1);
                g = (e / 32) % 8;
                kc = unpack(1, e, kb);
                if (kcode_twos && kc[kb - 1]) kc -= (64'sd1 <<< kb);
                r.elem = 8'(e);
                r.key = sat32(rne_shift((kc * 65536 + key_zero[g]) * key_scale[g], 16));
                t = rne_shift(work[e] * ((lg == 6) ? 2097152 : (lg == 7 ? 1482910 : 1048576)), 24);
                r.value = sat32(rne_shift(t * sign_vec[e], 16));
                expected_elems.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function void check_element(logic [7:0] elem, logic signed [31:0] key,
                                logic signed [31:0] value);
        t_elem_result r;
        if (expected_elems.size() == 0) begin
            $error("unexpected result: element_index %0d", elem);
            errors++;
            return;
        end
        r = expected_elems.pop_front();
        if (elem !== r.elem) begin
            $error("element_index: expected %0d, got %0d", r.elem, elem);
            errors++;
        end
        if (key !== r.key) begin
            $error("key_result: expected %0d, got %0d", r.key, key);
            errors++;
        end
        if (value !== r.value) begin
            $error("value_result: expected %0d, got %0d", r.value, value);
            errors++;
        end
    endfunction
endclass

module kv_cache_dequant_hadamard_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DrainCycles = 6000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [3:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_cmd;
    logic [7:0]         i_index;
    logic signed [23:0] i_data_a;
    logic signed [23:0] i_data_b;
    logic signed [23:0] i_data_c;
    logic [7:0]         i_packed_byte;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [7:0]         o_element_index;
    logic signed [31:0] o_key_result;
    logic signed [31:0] o_value_result;

    dequant_predictor model = new();
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    int  hold_left;

    kv_cache_dequant_hadamard_unit u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver stall: random, or one long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 2000;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check each accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            model.check_element(o_element_index, o_key_result, o_value_result);
    end

    function automatic logic signed [23:0] rand24();
        case ($urandom_range(7))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return {$urandom_range(1) ? 24'hFFFFFF : 24'h000000};
            default: return 24'($urandom);
        endcase
    endfunction

    // Offer one item at the falling edge, hold it until accepted.
    task automatic send_item(kvdh_pkg::t_cmd cmd, logic [7:0] idx, logic signed [23:0] a,
                             logic signed [23:0] b, logic signed [23:0] c,
                             logic [7:0] pbyte);
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_index <= idx;
        i_data_a <= a;
        i_data_b <= b;
        i_data_c <= c;
        i_packed_byte <= pbyte;
        do @(posedge i_clk); while (o_in_stall);
        model.note_command(cmd, idx, a, b, c, pbyte);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
    endtask

    task automatic send_random(bit read_only);
        kvdh_pkg::t_cmd cmd;
        int   r;
        r = $urandom_range(99);
        if (read_only || r < 40) cmd = kvdh_pkg::CMD_READ;
        else if (r < 43) cmd = kvdh_pkg::CMD_COMPUTE;
        else if (r < 46) cmd = kvdh_pkg::CMD_NOP;
        else cmd = kvdh_pkg::t_cmd'($urandom_range(4));
        send_item(cmd, (cmd == kvdh_pkg::CMD_GROUP && $urandom_range(1)) ?
                  8'($urandom_range(15)) : 8'($urandom_range(255)),
                  rand24(), rand24(), rand24(), 8'($urandom_range(255)));
    endtask

    // Write one register while the block is idle, then leave a gap.
    task automatic write_reg(logic [1:0] idx, logic [3:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (model.expected_elems.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    initial begin
        #25ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_cmd = '0;
        i_index = '0;
        i_data_a = '0;
        i_data_b = '0;
        i_data_c = '0;
        i_packed_byte = '0;
        i_out_stall = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        send_idle_pct = 33;
        recv_idle_pct = 50;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill every store, then a full-size transform.
        write_reg(kvdh_pkg::REG_HEAD_LOG2, 4'd8);
        for (int i = 0; i < 256; i++) begin
            send_item(kvdh_pkg::CMD_CENTROID, 8'(i), rand24(), '0, '0, '0);
            send_item(kvdh_pkg::CMD_SIGN, 8'(i), rand24(), '0, '0, '0);
            send_item(kvdh_pkg::CMD_KEY_BYTE, 8'(i), '0, '0, '0, 8'($urandom_range(255)));
            send_item(kvdh_pkg::CMD_VAL_BYTE, 8'(i), '0, '0, '0, 8'($urandom_range(255)));
        end
        for (int g = 0; g < 8; g++)
            send_item(kvdh_pkg::CMD_GROUP, 8'(g), rand24(), rand24(), rand24(), '0);
        send_item(kvdh_pkg::CMD_COMPUTE, '0, '0, '0, '0, '0);

        // Directed extremes, ignored commands and index wrap.
        send_item(kvdh_pkg::CMD_GROUP, 8'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, '0);
        send_item(kvdh_pkg::CMD_GROUP, 8'd1, 24'sh800000, 24'sh800000, 24'sh800000, '0);
        send_item(kvdh_pkg::CMD_GROUP, 8'd9, 24'sh123456, 24'sh654321, 24'sh0F0F0F, '0);
        send_item(kvdh_pkg::CMD_CENTROID, 8'd0, 24'sh800000, '0, '0, '0);
        send_item(kvdh_pkg::CMD_CENTROID, 8'd255, 24'sh7FFFFF, '0, '0, '0);
        send_item(kvdh_pkg::CMD_SIGN, 8'd0, 24'sh800000, '0, '0, '0);
        send_item(kvdh_pkg::CMD_SIGN, 8'd255, 24'sh7FFFFF, '0, '0, '0);
        send_item(kvdh_pkg::CMD_KEY_BYTE, 8'd0, '0, '0, '0, 8'hFF);
        send_item(kvdh_pkg::CMD_VAL_BYTE, 8'd0, '0, '0, '0, 8'hFF);
        send_item(kvdh_pkg::CMD_VAL_BYTE, 8'd255, '0, '0, '0, 8'h00);
        send_item(kvdh_pkg::CMD_COMPUTE, '0, '0, '0, '0, '0);
        send_item(kvdh_pkg::CMD_READ, 8'd0, '0, '0, '0, '0);
        send_item(kvdh_pkg::CMD_READ, 8'd255, '0, '0, '0, '0);
        send_item(kvdh_pkg::CMD_READ, 8'd32, '0, '0, '0, '0);
        send_item(kvdh_pkg::CMD_NOP, 8'hFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 8'hFF);
        send_item(kvdh_pkg::CMD_READ, 8'd200, '0, '0, '0, '0);
        drain();
        write_reg(kvdh_pkg::REG_HEAD_LOG2, 4'd6);
        write_reg(kvdh_pkg::REG_KEY_SIGNED, 4'd1);
        send_item(kvdh_pkg::CMD_READ, 8'hFF, '0, '0, '0, '0);
        send_item(kvdh_pkg::CMD_READ, 8'h40, '0, '0, '0, '0);

        // Random phases, each with its own register setting.
        for (int p = 0; p < 8; p++) begin
            drain();
            send_idle_pct = (p < 3) ? 33 : (p < 6 ? 50 : 0);
            recv_idle_pct = (p < 3) ? 50 : (p < 6 ? 33 : 0);
            case (p)
                0: begin
                    write_reg(kvdh_pkg::REG_HEAD_LOG2, 4'd0);
                    write_reg(kvdh_pkg::REG_KEY_BITS, 4'd0);
                    write_reg(kvdh_pkg::REG_VAL_BITS, 4'd2);
                    write_reg(kvdh_pkg::REG_KEY_SIGNED, 4'd1);
                end
                1: begin
                    write_reg(kvdh_pkg::REG_HEAD_LOG2, 4'd15);
                    write_reg(kvdh_pkg::REG_KEY_BITS, 4'd15);
                    write_reg(kvdh_pkg::REG_VAL_BITS, 4'd8);
                    write_reg(kvdh_pkg::REG_KEY_SIGNED, 4'd0);
                end
                2: begin
                    write_reg(kvdh_pkg::REG_HEAD_LOG2, 4'd6);
                    write_reg(kvdh_pkg::REG_KEY_BITS, 4'd8);
                    write_reg(kvdh_pkg::REG_VAL_BITS, 4'd15);
                    write_reg(kvdh_pkg::REG_KEY_SIGNED, 4'd1);
                end
                default: begin
                    write_reg(kvdh_pkg::REG_HEAD_LOG2,
                              $urandom_range(1) ? 4'd6 : 4'($urandom_range(15)));
                    write_reg(kvdh_pkg::REG_KEY_BITS, 4'($urandom_range(15)));
                    write_reg(kvdh_pkg::REG_VAL_BITS, 4'($urandom_range(15)));
                    write_reg(kvdh_pkg::REG_KEY_SIGNED, 4'($urandom_range(1)));
                end
            endcase
            // Long receiver hold-off while reads keep coming.
            if (p == 4) begin
                hold_req = 1'b1;
                repeat (12) send_random(1'b1);
            end
            repeat (70) send_random(1'b0);
        end
        drain();

        if (model.errors == 0 && model.expected_elems.size() == 0) begin
            $display("SUCCESS");
        end else begin
            if (model.expected_elems.size() != 0)
                $error("%0d results never arrived", model.expected_elems.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule

/* kv_cache_dequant_hadamard_unit.f */
+incdir+design
design/kvdh_pkg.sv
design/kvdh_ram.sv
design/kvdh_ctrl.sv
design/kvdh_datapath.sv
design/kv_cache_dequant_hadamard_unit.sv
sim/kv_cache_dequant_hadamard_unit_tb.sv
